### rtl/atss_pkg.sv
// Shared types and constants for the arctangent soft saturator.
// Used by the top level, the pipelined reciprocal unit and the port checker.
// Depends on nothing.
package atss_pkg;

   // Width of the gain registers and their reset values (1.0 in each format)
   localparam int GAIN_BITS = 16;
   localparam logic [GAIN_BITS-1:0] INPUT_GAIN_RESET = 16'd4096;
   localparam logic [GAIN_BITS-1:0] DRIVE_GAIN_RESET = 16'd1024;

   // Noise floor of -96 dB of full scale, as a fraction in Q32
   localparam logic [63:0] FLOOR_Q32 = 64'd68070;

   // Fixed-point layout of the shaping path
   localparam int FRAC_BITS = 30;
   localparam int TQ_BITS   = 40;
   localparam int Z_BITS    = 31;
   localparam int Q_BITS    = 30;
   localparam int P_BITS    = 32;
   localparam int PROD_BITS = 64;

   localparam logic [TQ_BITS-1:0] TQ_ONE = 40'h00_4000_0000;
   localparam logic [Z_BITS-1:0]  Z_ONE  = 31'h4000_0000;

   typedef logic signed [P_BITS-1:0] coef_type;

   // Polynomial for atan in Q30; the last two steps multiply by z and by 2/pi
   localparam int NUM_STEPS    = 6;
   localparam int HORNER_STEPS = 4;
   localparam coef_type COEF_A9     = 32'sd22371519;
   localparam coef_type TWO_OVER_PI = 32'sd683565276;
   localparam coef_type STEP_ADD [NUM_STEPS] = '{
      -32'sd91410863,
      32'sd193424926,
      -32'sd354656388,
      32'sd1073597943,
      32'sd0,
      32'sd0
   };

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_INPUT_GAIN = 1'b0,
      CSR_DRIVE_GAIN = 1'b1
   } csr_index_type;

   // Per-request flags that travel alongside the data
   typedef struct packed {
      logic neg;
      logic zero;
      logic reflect;
   } side_type;

   // Pipeline depth: gain stages, reciprocal unit, square, polynomial, output
   localparam int RECIP_STAGES = Q_BITS + 1;
   localparam int LATENCY      = 3 + RECIP_STAGES + 3 + 2 * NUM_STEPS + 3;

endpackage

### rtl/arctangent_soft_saturator.sv
// Arctangent soft saturator, top level: gain stages, atan shaping, output rounding.
// Depends on atss_pkg and atss_recip.
//
// Usage:
//   A request is taken at every rising edge with start high and busy low; busy
//   stays low, so one sample may be offered in every cycle. The sample sits on
//   req_sample_in at that edge.
//   The result appears on rsp_sample_out for one cycle, marked by rsp_valid,
//   after passing through every stage named below. Results come out in
//   request order and the receiver takes each one in its cycle; it cannot stall.
//   Throughput is one sample per clock. A request passes three gain stages,
//   the reciprocal unit (an entry stage and then one quotient bit per stage
//   over 30 stages), three square stages, twelve polynomial stages and three
//   output stages.
//   The user must write the two gain registers through csr_write_en, csr_index and
//   csr_wdata only while no request is in flight; the block does not enforce it.
//   Reset is synchronous: it empties the pipeline, so no result follows a
//   request taken before or during reset, and sets both gains to 1.0.
module arctangent_soft_saturator #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_in,
   output logic                                rsp_valid,
   output logic signed [SAMPLE_BITS-1:0]       rsp_sample_out,
   input  logic                                csr_write_en,
   input  atss_pkg::csr_index_type             csr_index,
   input  logic [atss_pkg::GAIN_BITS-1:0]      csr_wdata
);
   import atss_pkg::*;

   localparam logic [63:0] FLOOR_FULL =
      ((FLOOR_Q32 << (SAMPLE_BITS - 1)) + 64'h8000_0000) >> 32;
   localparam logic [SAMPLE_BITS-1:0] FLOOR_LSB = FLOOR_FULL[SAMPLE_BITS-1:0];
   localparam coef_type Z_ONE_S = coef_type'({1'b0, Z_ONE});
   localparam logic [SAMPLE_BITS+FRAC_BITS-1:0] ROUND_HALF =
      (SAMPLE_BITS+FRAC_BITS)'(1) << (FRAC_BITS - 1);
   localparam logic [SAMPLE_BITS-1:0] MAG_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   // Product of a signed multiply, divided by 2^30 with truncation toward zero
   function automatic coef_type trunc_q30(input logic signed [PROD_BITS-1:0] prod);
      logic signed [PROD_BITS-1:0] adj;
      adj = prod[PROD_BITS-1] ? (prod + ((64'sd1 <<< FRAC_BITS) - 64'sd1)) : prod;
      return adj[FRAC_BITS+P_BITS-1:FRAC_BITS];
   endfunction

   // Gain registers
   logic [GAIN_BITS-1:0] input_gain_ff;
   logic [GAIN_BITS-1:0] drive_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         input_gain_ff <= INPUT_GAIN_RESET;
         drive_gain_ff <= DRIVE_GAIN_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_INPUT_GAIN: input_gain_ff <= csr_wdata;
            CSR_DRIVE_GAIN: drive_gain_ff <= csr_wdata;
         endcase
      end
   end

   // The pipeline takes a request in every cycle
   assign busy = 1'b0;

   // Stage 1: sign, magnitude and the noise floor
   logic [SAMPLE_BITS-1:0] x_in;
   logic [SAMPLE_BITS-1:0] abs_in;
   logic [SAMPLE_BITS-1:0] mag_in;
   side_type               side1_in;
   logic                   valid1_ff;
   side_type               side1_ff;
   logic [SAMPLE_BITS-1:0] mag1_ff;

   assign x_in     = req_sample_in;
   assign abs_in   = x_in[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - x_in) : x_in;
   assign mag_in   = (abs_in < FLOOR_LSB) ? FLOOR_LSB : abs_in;
   assign side1_in = '{neg: x_in[SAMPLE_BITS-1], zero: (x_in == '0), reflect: 1'b0};

   // Stage 2: trim gain; stage 3: drive gain, keeping t in Q30
   logic [SAMPLE_BITS+GAIN_BITS-1:0]   prodg_in;
   logic [SAMPLE_BITS+2*GAIN_BITS-1:0] u_in;
   logic [TQ_BITS-1:0]                 tq_in;
   logic                               valid2_ff;
   side_type                           side2_ff;
   logic [SAMPLE_BITS+GAIN_BITS-1:0]   prodg_ff;
   logic                               valid3_ff;
   side_type                           side3_ff;
   logic [TQ_BITS-1:0]                 tq_ff;

   assign prodg_in = mag1_ff * input_gain_ff;
   assign u_in     = prodg_ff * drive_gain_ff;
   assign tq_in    = u_in[SAMPLE_BITS+30:SAMPLE_BITS-9];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         valid1_ff <= start && !busy;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      side1_ff <= side1_in;
      mag1_ff  <= mag_in;
      side2_ff <= side1_ff;
      prodg_ff <= prodg_in;
      side3_ff <= side2_ff;
      tq_ff    <= tq_in;
   end

   // Reciprocal for values of t above one
   logic               recip_valid;
   side_type           recip_side;
   logic [Z_BITS-1:0]  recip_z;

   atss_recip u_recip (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid3_ff),
      .in_side   (side3_ff),
      .in_tq     (tq_ff),
      .out_valid (recip_valid),
      .out_side  (recip_side),
      .out_z     (recip_z)
   );

   // Register z, then square it and keep w = z*z in Q30
   logic                  zs_valid_ff;
   side_type              zs_side_ff;
   logic [Z_BITS-1:0]     z_ff;
   logic [2*Z_BITS-1:0]   zz_in;
   logic                  sq_valid_ff;
   side_type              sq_side_ff;
   logic [2*Z_BITS-1:0]   zz_ff;
   logic [Z_BITS-1:0]     z0_ff;
   logic                  w_valid_ff;
   side_type              w_side_ff;
   logic [Z_BITS-1:0]     w_ff;
   logic [Z_BITS-1:0]     z1_ff;

   assign zz_in = z_ff * z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zs_valid_ff <= 1'b0;
         sq_valid_ff <= 1'b0;
         w_valid_ff  <= 1'b0;
      end else begin
         zs_valid_ff <= recip_valid;
         sq_valid_ff <= zs_valid_ff;
         w_valid_ff  <= sq_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      zs_side_ff <= recip_side;
      z_ff       <= recip_z;
      sq_side_ff <= zs_side_ff;
      zz_ff      <= zz_in;
      z0_ff      <= z_ff;
      w_side_ff  <= sq_side_ff;
      w_ff       <= zz_ff[FRAC_BITS+Z_BITS-1:FRAC_BITS];
      z1_ff      <= z0_ff;
   end

   // Horner steps, then the products with z and with 2/pi. Each step has a
   // multiply stage and a truncate-and-add stage.
   logic                         mvalid_in [NUM_STEPS];
   logic                         mvalid_ff [NUM_STEPS];
   side_type                     mside_in  [NUM_STEPS];
   side_type                     mside_ff  [NUM_STEPS];
   logic signed [PROD_BITS-1:0]  mprod_in  [NUM_STEPS];
   logic signed [PROD_BITS-1:0]  mprod_ff  [NUM_STEPS];
   logic [Z_BITS-1:0]            mw_in     [NUM_STEPS];
   logic [Z_BITS-1:0]            mw_ff     [NUM_STEPS];
   logic [Z_BITS-1:0]            mz_in     [NUM_STEPS];
   logic [Z_BITS-1:0]            mz_ff     [NUM_STEPS];
   logic                         avalid_in [NUM_STEPS];
   logic                         avalid_ff [NUM_STEPS];
   side_type                     aside_in  [NUM_STEPS];
   side_type                     aside_ff  [NUM_STEPS];
   coef_type                     ap_in     [NUM_STEPS];
   coef_type                     ap_ff     [NUM_STEPS];
   logic [Z_BITS-1:0]            aw_in     [NUM_STEPS];
   logic [Z_BITS-1:0]            aw_ff     [NUM_STEPS];
   logic [Z_BITS-1:0]            az_in     [NUM_STEPS];
   logic [Z_BITS-1:0]            az_ff     [NUM_STEPS];

   for (genvar j = 0; j < NUM_STEPS; j++) begin : g_poly
      logic              src_valid;
      side_type          src_side;
      coef_type          src_p;
      logic [Z_BITS-1:0] src_w;
      logic [Z_BITS-1:0] src_z;
      coef_type          oper;

      if (j == 0) begin : g_first
         assign src_valid = w_valid_ff;
         assign src_side  = w_side_ff;
         assign src_p     = COEF_A9;
         assign src_w     = w_ff;
         assign src_z     = z1_ff;
      end else begin : g_next
         assign src_valid = avalid_ff[j-1];
         assign src_side  = aside_ff[j-1];
         assign src_p     = ap_ff[j-1];
         assign src_w     = aw_ff[j-1];
         assign src_z     = az_ff[j-1];
      end

      if (j < HORNER_STEPS) begin : g_by_w
         assign oper = coef_type'({1'b0, src_w});
      end else if (j == HORNER_STEPS) begin : g_by_z
         assign oper = coef_type'({1'b0, src_z});
      end else begin : g_by_const
         assign oper = TWO_OVER_PI;
      end

      assign mvalid_in[j] = src_valid;
      assign mside_in[j]  = src_side;
      assign mprod_in[j]  = src_p * oper;
      assign mw_in[j]     = src_w;
      assign mz_in[j]     = src_z;

      assign avalid_in[j] = mvalid_ff[j];
      assign aside_in[j]  = mside_ff[j];
      assign ap_in[j]     = STEP_ADD[j] + trunc_q30(mprod_ff[j]);
      assign aw_in[j]     = mw_ff[j];
      assign az_in[j]     = mz_ff[j];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NUM_STEPS; j++) begin
            mvalid_ff[j] <= 1'b0;
            avalid_ff[j] <= 1'b0;
         end
      end else begin
         mvalid_ff <= mvalid_in;
         avalid_ff <= avalid_in;
      end
   end

   always_ff @(posedge clock) begin
      mside_ff <= mside_in;
      mprod_ff <= mprod_in;
      mw_ff    <= mw_in;
      mz_ff    <= mz_in;
      aside_ff <= aside_in;
      ap_ff    <= ap_in;
      aw_ff    <= aw_in;
      az_ff    <= az_in;
   end

   // Cap the shaped value to [0, 1] and undo the reflection
   coef_type           pfin;
   logic [Z_BITS-1:0]  clamp_in;
   logic [Z_BITS-1:0]  r_in;
   logic               r_valid_ff;
   side_type           r_side_ff;
   logic [Z_BITS-1:0]  r_ff;

   assign pfin = ap_ff[NUM_STEPS-1];

   always_comb begin
      if (pfin < 0) begin
         clamp_in = '0;
      end else if (pfin > Z_ONE_S) begin
         clamp_in = Z_ONE;
      end else begin
         clamp_in = pfin[Z_BITS-1:0];
      end
      r_in = aside_ff[NUM_STEPS-1].reflect ? (Z_ONE - clamp_in) : clamp_in;
   end

   // Scale to the sample format with rounding
   logic [SAMPLE_BITS+FRAC_BITS-1:0] scaled_in;
   logic                             sc_valid_ff;
   side_type                         sc_side_ff;
   logic [SAMPLE_BITS-1:0]           mag_out_ff;

   assign scaled_in = {r_ff, {(SAMPLE_BITS-1){1'b0}}} + ROUND_HALF;

   // Saturate just below full scale, then restore the sign
   logic [SAMPLE_BITS-1:0] sat_in;
   logic [SAMPLE_BITS-1:0] out_in;
   logic                   rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] rsp_sample_ff;

   always_comb begin
      sat_in = mag_out_ff[SAMPLE_BITS-1] ? MAG_MAX : mag_out_ff;
      if (sc_side_ff.zero) begin
         out_in = '0;
      end else if (sc_side_ff.neg) begin
         out_in = SAMPLE_BITS'(0) - sat_in;
      end else begin
         out_in = sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff   <= 1'b0;
         sc_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         r_valid_ff   <= avalid_ff[NUM_STEPS-1];
         sc_valid_ff  <= r_valid_ff;
         rsp_valid_ff <= sc_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      r_side_ff     <= aside_ff[NUM_STEPS-1];
      r_ff          <= r_in;
      sc_side_ff    <= r_side_ff;
      mag_out_ff    <= scaled_in[SAMPLE_BITS+FRAC_BITS-1:FRAC_BITS];
      rsp_sample_ff <= out_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

endmodule

### rtl/atss_recip.sv
// Pipelined reciprocal unit: floor(2^60 / tq) with one quotient bit per stage.
// Decides whether the request is reflected and passes tq through otherwise.
// Depends on atss_pkg.
module atss_recip (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  atss_pkg::side_type             in_side,
   input  logic [atss_pkg::TQ_BITS-1:0]   in_tq,
   output logic                           out_valid,
   output atss_pkg::side_type             out_side,
   output logic [atss_pkg::Z_BITS-1:0]    out_z
);
   import atss_pkg::*;

   logic                valid_in [RECIP_STAGES];
   logic                valid_ff [RECIP_STAGES];
   side_type            side_in  [RECIP_STAGES];
   side_type            side_ff  [RECIP_STAGES];
   logic [TQ_BITS-1:0]  div_in   [RECIP_STAGES];
   logic [TQ_BITS-1:0]  div_ff   [RECIP_STAGES];
   logic [TQ_BITS-1:0]  rem_in   [RECIP_STAGES];
   logic [TQ_BITS-1:0]  rem_ff   [RECIP_STAGES];
   logic [Q_BITS-1:0]   quo_in   [RECIP_STAGES];
   logic [Q_BITS-1:0]   quo_ff   [RECIP_STAGES];

   // Entry stage: values above one are reflected, and the partial remainder
   // starts at the upper part of the dividend 2^60.
   assign valid_in[0] = in_valid;
   assign side_in[0]  = '{neg: in_side.neg, zero: in_side.zero, reflect: (in_tq > TQ_ONE)};
   assign div_in[0]   = in_tq;
   assign rem_in[0]   = TQ_ONE;
   assign quo_in[0]   = '0;

   // Restoring division, one quotient bit per stage, most significant first
   for (genvar k = 1; k < RECIP_STAGES; k++) begin : g_step
      logic [TQ_BITS:0]   shifted;
      logic [TQ_BITS+1:0] diff;
      logic               take;

      assign shifted     = {rem_ff[k-1], 1'b0};
      assign diff        = {1'b0, shifted} - {2'b00, div_ff[k-1]};
      assign take        = ~diff[TQ_BITS+1];
      assign valid_in[k] = valid_ff[k-1];
      assign side_in[k]  = side_ff[k-1];
      assign div_in[k]   = div_ff[k-1];
      assign rem_in[k]   = take ? diff[TQ_BITS-1:0] : shifted[TQ_BITS-1:0];
      assign quo_in[k]   = {quo_ff[k-1][Q_BITS-2:0], take};
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < RECIP_STAGES; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Data registers
   always_ff @(posedge clock) begin
      side_ff <= side_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   // The quotient replaces tq only for reflected requests
   assign out_valid = valid_ff[RECIP_STAGES-1];
   assign out_side  = side_ff[RECIP_STAGES-1];
   assign out_z     = side_ff[RECIP_STAGES-1].reflect ?
                      {1'b0, quo_ff[RECIP_STAGES-1]} :
                      div_ff[RECIP_STAGES-1][Z_BITS-1:0];

endmodule

### rtl/atss_checker.sv
// Port checker for the arctangent soft saturator, attached by a bind statement.
// Watches the request and result ports over the pipeline latency. Depends on atss_pkg.
module atss_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input logic                          rsp_valid,
   input logic signed [SAMPLE_BITS-1:0] rsp_sample_out
);
   import atss_pkg::*;

   localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic accept;

   assign accept = start && !busy;

   // Every request gives its result after the fixed latency
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("request taken without a result after the pipeline latency");

   // No result without a request taken one latency earlier
   a_no_stray_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept && !reset, LATENCY))
      else $error("result without a matching request");

   // A zero sample gives a zero result
   a_zero_in_zero_out: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_sample_in == '0)) |-> ##LATENCY (rsp_sample_out == '0))
      else $error("zero sample did not give zero");

   // A non-negative sample never gives a negative result
   a_sign_kept: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_sample_in[SAMPLE_BITS-1]) |-> ##LATENCY !rsp_sample_out[SAMPLE_BITS-1])
      else $error("sign of a non-negative sample was lost");

   // The result magnitude stays below full scale
   a_below_full_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample_out != MOST_NEG))
      else $error("result reached negative full scale");

endmodule

bind arctangent_soft_saturator atss_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_atss_checker (.*);
